/* design/sortl_pkg.sv */
// ----------------------------------------------------------------------------
// sortl_pkg
// Shared constants, operation codes and the request word type for the
// sorted list table.
// ----------------------------------------------------------------------------
package sortl_pkg;

  // table size and derived widths
  localparam int CAPACITY  = 16;
  localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  // field widths of the channel words
  localparam int KIND_W    = 3;
  localparam int VAL_W     = 32;
  localparam int POS_IN_W  = 8;
  localparam int POS_OUT_W = 4;
  localparam int FILL_W    = 5;

  // width used to compare a requested position against the count
  localparam int CMP_W     = (POS_IN_W > CNT_W) ? POS_IN_W : CNT_W;

  // operation codes
  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT     = 3'd0,
    KIND_REMOVE_VAL = 3'd1,
    KIND_READ_POS   = 3'd2,
    KIND_FIND_VAL   = 3'd3,
    KIND_REMOVE_POS = 3'd4
  } kind_t;

  // registered request word handed from the input stage to the table
  typedef struct packed {
    logic                      valid;
    logic [KIND_W-1:0]         kind;
    logic signed [VAL_W-1:0]   value;
    logic [POS_IN_W-1:0]       pos;
  } req_t;

endpackage

/* design/sortl_in_if.sv */
// ----------------------------------------------------------------------------
// sortl_in_if
// Request channel: valid/ready handshake carrying one operation word.
// ----------------------------------------------------------------------------
interface sortl_in_if;

  logic                                    valid;
  logic                                    ready;
  logic [sortl_pkg::KIND_W-1:0]            kind;
  logic signed [sortl_pkg::VAL_W-1:0]      value_in;
  logic [sortl_pkg::POS_IN_W-1:0]          position_in;

  modport source (output valid, kind, value_in, position_in, input ready);
  modport sink   (input valid, kind, value_in, position_in, output ready);

endinterface

/* design/sortl_out_if.sv */
// ----------------------------------------------------------------------------
// sortl_out_if
// Result channel: valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
interface sortl_out_if;

  logic                                    valid;
  logic                                    ready;
  logic                                    ok;
  logic signed [sortl_pkg::VAL_W-1:0]      value_out;
  logic [sortl_pkg::POS_OUT_W-1:0]         position_out;
  logic [sortl_pkg::FILL_W-1:0]            fill_count;

  modport source (output valid, ok, value_out, position_out, fill_count, input ready);
  modport sink   (input valid, ok, value_out, position_out, fill_count, output ready);

endinterface

/* design/sorted_list_table.sv */
// Path: an accepted word passes the input register, then the result
// register. Throughput: one word per cycle unless out_ch.ready stalls; the
// compare and shift finish in the cycle after the input register.
// Reset: synchronous, active low; clears the fill count and both valid
// flags. Entry registers are not reset and are only read below the count.
// ----------------------------------------------------------------------------
// sorted_list_table
// Ascending sorted table of signed values with insert, remove by value,
// read at position, find and remove at position.
// ----------------------------------------------------------------------------
module sorted_list_table (
  input  logic          clk,
  input  logic          rst_n,
  sortl_in_if.sink      in_ch,
  sortl_out_if.source   out_ch
);

  sortl_pkg::req_t  req;
  logic             advance;

  // input register
  sortl_in_reg u_in_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .advance (advance),
    .req     (req)
  );

  // table and result register
  sortl_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .advance (advance),
    .out_ch  (out_ch)
  );

endmodule

/* design/sortl_in_reg.sv */
// ----------------------------------------------------------------------------
// sortl_in_reg
// Input register: captures one request word per cycle and holds it while
// the table stage is stalled.
// ----------------------------------------------------------------------------
module sortl_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  sortl_in_if.sink           in_ch,
  input  logic               advance,
  output sortl_pkg::req_t    req
);

  logic                                   valid_r;
  logic [sortl_pkg::KIND_W-1:0]           kind_r;
  logic signed [sortl_pkg::VAL_W-1:0]     value_r;
  logic [sortl_pkg::POS_IN_W-1:0]         pos_r;

  // take a new word when empty or when the held one moves on
  assign in_ch.ready = !valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      kind_r  <= in_ch.kind;
      value_r <= in_ch.value_in;
      pos_r   <= in_ch.position_in;
    end
  end

  assign req.valid = valid_r;
  assign req.kind  = kind_r;
  assign req.value = value_r;
  assign req.pos   = pos_r;

endmodule

/* design/sortl_table.sv */
// ----------------------------------------------------------------------------
// sortl_table
// Sorted entry registers with fill count. Compares the request value
// against all entries in parallel, shifts the array for insert or remove,
// and registers the result word.
// ----------------------------------------------------------------------------
module sortl_table (
  input  logic               clk,
  input  logic               rst_n,
  input  sortl_pkg::req_t    req,
  output logic               advance,
  sortl_out_if.source        out_ch
);

  localparam int CAP   = sortl_pkg::CAPACITY;
  localparam int IDX_W = sortl_pkg::IDX_W;
  localparam int CNT_W = sortl_pkg::CNT_W;
  localparam int VAL_W = sortl_pkg::VAL_W;
  localparam int CMP_W = sortl_pkg::CMP_W;

  logic signed [VAL_W-1:0]  entries_r [CAP];
  logic signed [VAL_W-1:0]  entries_nxt [CAP];
  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         count_nxt;

  logic                     out_valid_r;
  logic                     ok_r;
  logic signed [VAL_W-1:0]  vout_r;
  logic [sortl_pkg::POS_OUT_W-1:0] pout_r;
  logic [sortl_pkg::FILL_W-1:0]    fill_r;

  logic                     fire;
  logic [CAP-1:0]           ltv;
  logic [CAP-1:0]           eqv;
  logic [CNT_W-1:0]         at;
  logic [IDX_W-1:0]         at_idx;
  logic [IDX_W-1:0]         pos_idx;
  logic                     full;
  logic                     found;
  logic                     pos_ok;
  logic signed [VAL_W-1:0]  pos_entry;

  logic                     do_ins;
  logic                     do_rm;
  logic [IDX_W-1:0]         rm_idx;
  logic                     ok_nxt;
  logic signed [VAL_W-1:0]  vout_nxt;
  logic [sortl_pkg::POS_OUT_W-1:0] pout_nxt;

  // stage moves when the result register is free or being drained
  assign advance = !out_valid_r || out_ch.ready;
  assign fire    = req.valid && advance;

  // parallel compare against every live entry
  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      ltv[i] = (CNT_W'(i) < count_r) && (entries_r[i] < req.value);
      eqv[i] = (entries_r[i] == req.value);
    end
  end

  // entries below the value form a prefix; its length is the insert slot
  assign at      = CNT_W'($countones(ltv));
  assign at_idx  = IDX_W'(at);
  assign pos_idx = IDX_W'(req.pos);
  assign full    = (count_r == CNT_W'(CAP));
  assign found   = (at < count_r) && eqv[at_idx];
  assign pos_ok  = (CMP_W'(req.pos) < CMP_W'(count_r));
  assign pos_entry = entries_r[pos_idx];

  // operation decode
  always_comb begin
    do_ins   = 1'b0;
    do_rm    = 1'b0;
    rm_idx   = pos_idx;
    ok_nxt   = 1'b0;
    vout_nxt = '0;
    pout_nxt = '0;
    case (req.kind)
      sortl_pkg::KIND_INSERT: begin
        do_ins = !full;
        ok_nxt = !full;
      end
      sortl_pkg::KIND_REMOVE_VAL: begin
        do_rm  = found;
        rm_idx = at_idx;
        ok_nxt = found;
      end
      sortl_pkg::KIND_READ_POS: begin
        ok_nxt = pos_ok;
        if (pos_ok) begin
          vout_nxt = pos_entry;
        end
      end
      sortl_pkg::KIND_FIND_VAL: begin
        ok_nxt = found;
        if (found) begin
          pout_nxt = sortl_pkg::POS_OUT_W'(at);
        end
      end
      sortl_pkg::KIND_REMOVE_POS: begin
        do_rm  = pos_ok;
        ok_nxt = pos_ok;
        if (pos_ok) begin
          vout_nxt = pos_entry;
        end
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
  end

  // shifted array and count
  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      entries_nxt[i] = entries_r[i];
      if (do_ins) begin
        if (IDX_W'(i) == at_idx) begin
          entries_nxt[i] = req.value;
        end else if (IDX_W'(i) > at_idx && i > 0) begin
          entries_nxt[i] = entries_r[(i > 0) ? i - 1 : 0];
        end
      end else if (do_rm) begin
        if (IDX_W'(i) >= rm_idx && i < CAP - 1) begin
          entries_nxt[i] = entries_r[(i < CAP - 1) ? i + 1 : i];
        end
      end
    end
    count_nxt = count_r;
    if (do_ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_rm) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // entry registers, no reset
  always_ff @(posedge clk) begin
    if (fire && (do_ins || do_rm)) begin
      for (int i = 0; i < CAP; i++) begin
        entries_r[i] <= entries_nxt[i];
      end
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (fire) begin
      count_r <= count_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      ok_r   <= ok_nxt;
      vout_r <= vout_nxt;
      pout_r <= pout_nxt;
      fill_r <= sortl_pkg::FILL_W'(count_nxt);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.ok           = ok_r;
  assign out_ch.value_out    = vout_r;
  assign out_ch.position_out = pout_r;
  assign out_ch.fill_count   = fill_r;

endmodule

/* dv/sorted_list_table_tb.sv */
// ----------------------------------------------------------------------------
// sorted_list_table_tb
// Self-checking bench for the sorted list table. Request words are driven
// with random gaps while the result side stalls at random. A shadow copy of
// the table predicts every result word, and each returned word is compared
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module sorted_list_table_tb;
  import sortl_pkg::*;

  localparam int CYCLE_LIMIT  = 100000;
  localparam int DRAIN_CYCLES = 10;
  localparam int POS_IN_MAX   = (1 << POS_IN_W) - 1;

  // codes outside the defined operations
  localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct {
    logic                    ok;
    logic signed [VAL_W-1:0] value;
    logic [POS_OUT_W-1:0]    position;
    logic [FILL_W-1:0]       fill;
  } reply_t;

  logic clk;
  logic rst_n;

  sortl_in_if  in_ch ();
  sortl_out_if out_ch ();

  sorted_list_table dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow of the table contents as seen by accepted words
  logic signed [VAL_W-1:0] sorted_copy [CAPACITY];
  int unsigned             copy_count = 0;
  reply_t                  pending_replies [$];

  int unsigned send_gap_pct = 0;
  int unsigned take_gap_pct = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;
  bit          growing      = 1'b1;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("sorted_list_table test failed");
      $finish;
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= take_gap_pct);
  end

  // position of the first entry equal to v, or the count when absent
  function automatic int unsigned first_equal(logic signed [VAL_W-1:0] v);
    int unsigned i;
    for (i = 0; i < copy_count; i++) begin
      if (sorted_copy[i] == v) return i;
      if (v < sorted_copy[i]) break;
    end
    return copy_count;
  endfunction

  function automatic void drop_entry(int unsigned p);
    int unsigned i;
    for (i = p; i + 1 < copy_count; i++) sorted_copy[i] = sorted_copy[i + 1];
    copy_count--;
  endfunction

  // apply one operation to the shadow table and return the result word
  function automatic reply_t table_apply(logic [KIND_W-1:0] kind,
                                         logic signed [VAL_W-1:0] v,
                                         logic [POS_IN_W-1:0] pos);
    reply_t      r;
    int unsigned at;
    int unsigned i;
    r.ok       = 1'b0;
    r.value    = '0;
    r.position = '0;
    case (kind)
      KIND_INSERT: begin
        if (copy_count < CAPACITY) begin
          at = 0;
          while (at < copy_count && sorted_copy[at] < v) at++;
          for (i = copy_count; i > at; i--) sorted_copy[i] = sorted_copy[i - 1];
          sorted_copy[at] = v;
          copy_count++;
          r.ok = 1'b1;
        end
      end
      KIND_REMOVE_VAL: begin
        at = first_equal(v);
        if (at < copy_count) begin
          drop_entry(at);
          r.ok = 1'b1;
        end
      end
      KIND_READ_POS: begin
        if (pos < copy_count) begin
          r.value = sorted_copy[pos];
          r.ok    = 1'b1;
        end
      end
      KIND_FIND_VAL: begin
        at = first_equal(v);
        if (at < copy_count) begin
          r.position = POS_OUT_W'(at);
          r.ok       = 1'b1;
        end
      end
      KIND_REMOVE_POS: begin
        if (pos < copy_count) begin
          r.value = sorted_copy[pos];
          drop_entry(pos);
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    r.fill = FILL_W'(copy_count);
    return r;
  endfunction

  task automatic check_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  // predict on accepted request words, check accepted result words
  always @(posedge clk) begin : result_check
    reply_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        pending_replies.push_back(table_apply(in_ch.kind, in_ch.value_in, in_ch.position_in));
      if (out_ch.valid === 1'b1 && out_ch.ready) begin
        if (pending_replies.size() == 0) begin
          $display("%0t: unexpected result word, expected none, got ok %0b value %0h",
                   $time, out_ch.ok, out_ch.value_out);
          mismatch_cnt++;
        end else begin
          want = pending_replies.pop_front();
          check_field("ok", VAL_W'(want.ok), VAL_W'(out_ch.ok));
          check_field("value_out", want.value, out_ch.value_out);
          check_field("position_out", VAL_W'(want.position), VAL_W'(out_ch.position_out));
          check_field("fill_count", VAL_W'(want.fill), VAL_W'(out_ch.fill_count));
        end
      end
    end
  end

  // send one request word; returns at the falling edge after acceptance
  task automatic send_word(logic [KIND_W-1:0] kind, logic signed [VAL_W-1:0] v,
                           logic [POS_IN_W-1:0] pos);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= kind;
    in_ch.value_in    <= v;
    in_ch.position_in <= pos;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // values lean toward current entries and a small pool so that hits are common
  function automatic logic signed [VAL_W-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 25 && copy_count > 0) return sorted_copy[$urandom_range(0, copy_count - 1)];
    if (roll < 55) return $signed(VAL_W'($urandom_range(0, 8))) - 4;
    if (roll < 65) begin
      case ($urandom_range(0, 3))
        0:       return VAL_MIN;
        1:       return VAL_MAX;
        2:       return '0;
        default: return -1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [POS_IN_W-1:0] pick_position();
    if ($urandom_range(0, 99) < 75) return POS_IN_W'($urandom_range(0, copy_count));
    return POS_IN_W'($urandom_range(0, POS_IN_MAX));
  endfunction

  // operation mix follows the fill trend so the table swings between empty and full
  function automatic logic [KIND_W-1:0] pick_kind();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
    if (roll < (growing ? 70 : 15)) return KIND_INSERT;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return KIND_REMOVE_POS;
      4, 5, 6:    return KIND_REMOVE_VAL;
      7:          return KIND_READ_POS;
      default:    return KIND_FIND_VAL;
    endcase
  endfunction

  // extremes, duplicates, misses and spare codes from an empty table
  task automatic test_directed();
    send_word(KIND_REMOVE_VAL, '0, '0);
    send_word(KIND_READ_POS, '0, '0);
    send_word(KIND_FIND_VAL, '0, '0);
    send_word(KIND_REMOVE_POS, '0, '0);
    send_word(KIND_INSERT, VAL_MAX, '0);
    send_word(KIND_INSERT, VAL_MIN, '0);
    send_word(KIND_INSERT, '0, '0);
    send_word(KIND_INSERT, '0, '0);
    send_word(KIND_INSERT, -1, '0);
    send_word(KIND_FIND_VAL, '0, '0);
    send_word(KIND_FIND_VAL, 5, '0);
    send_word(KIND_FIND_VAL, VAL_MIN, '0);
    send_word(KIND_READ_POS, '0, 8'd4);
    send_word(KIND_READ_POS, '0, 8'd5);
    send_word(KIND_READ_POS, '0, POS_IN_W'(POS_IN_MAX));
    send_word(KIND_REMOVE_VAL, VAL_MIN, '0);
    // value below the first entry
    send_word(KIND_REMOVE_VAL, -5, '0);
    send_word(KIND_REMOVE_VAL, '0, '0);
    send_word(KIND_REMOVE_POS, '0, '0);
    send_word(KIND_REMOVE_POS, '0, 8'd2);
    send_word(KIND_REMOVE_POS, '0, 8'd1);
    send_word(KIND_SPARE_FIRST, '0, '0);
    send_word(KIND_SPARE_LAST, VAL_MAX, POS_IN_W'(POS_IN_MAX));
    // value above the last entry
    send_word(KIND_REMOVE_VAL, 1, '0);
    send_word(KIND_FIND_VAL, '0, '0);
  endtask

  // fill to capacity, insert into a full table, then drain and probe empty
  task automatic test_capacity();
    while (copy_count < CAPACITY) send_word(KIND_INSERT, pick_value(), pick_position());
    send_word(KIND_INSERT, pick_value(), pick_position());
    send_word(KIND_READ_POS, pick_value(), POS_IN_W'(CAPACITY - 1));
    send_word(KIND_FIND_VAL, sorted_copy[CAPACITY - 1], '0);
    while (copy_count > 0)
      send_word(KIND_REMOVE_POS, pick_value(), POS_IN_W'($urandom_range(0, copy_count - 1)));
    send_word(KIND_REMOVE_VAL, pick_value(), '0);
    send_word(KIND_READ_POS, pick_value(), '0);
    send_word(KIND_FIND_VAL, pick_value(), '0);
    send_word(KIND_REMOVE_POS, pick_value(), '0);
  endtask

  task automatic run_mix(int unsigned n_words);
    int unsigned i;
    for (i = 0; i < n_words; i++) begin
      if (copy_count == CAPACITY) growing = 1'b0;
      else if (copy_count == 0) growing = 1'b1;
      send_word(pick_kind(), pick_value(), pick_position());
    end
  endtask

  task automatic test_random_slow_receiver();
    send_gap_pct = 37;
    take_gap_pct = 74;
    run_mix(140);
  endtask

  task automatic test_random_slow_sender();
    send_gap_pct = 74;
    take_gap_pct = 37;
    run_mix(140);
  endtask

  task automatic test_random_full_rate();
    send_gap_pct = 0;
    take_gap_pct = 0;
    run_mix(140);
  endtask

  // main sequence
  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.kind         = KIND_INSERT;
    in_ch.value_in     = '0;
    in_ch.position_in  = '0;
    out_ch.ready       = 1'b0;
    send_gap_pct       = 37;
    take_gap_pct       = 74;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_capacity();
    test_random_slow_receiver();
    test_random_slow_sender();
    test_random_full_rate();

    in_ch.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("sorted_list_table test passed");
    end else begin
      $display("sorted_list_table test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
design/sortl_pkg.sv
design/sortl_in_if.sv
design/sortl_out_if.sv
design/sortl_in_reg.sv
design/sortl_table.sv
design/sorted_list_table.sv
dv/sorted_list_table_tb.sv
